// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk_i and quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IFF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/iff_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iff_pkg
// shared types, codes and character tables of the integer field formatter
// ---------------------------------------------------------------------------
package iff_pkg;

  localparam int VALUE_BITS_DEF     = 32;
  localparam int MAX_WIDTH_DEF      = 64;
  localparam int POINTER_DIGITS_DEF = 8;

  // fixed port field widths
  localparam int VALUE_W = 32;
  localparam int SPEC_W  = 24;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  // field positions and lengths, covers every legal parameter setting
  localparam int LEN_W   = 8;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_GT      = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_B       = 8'h62;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

  localparam logic [16*CHAR_W-1:0] DIGIT_CHARS = "0123456789abcdef";

  typedef struct packed {
    logic   load;
    logic   start;
    radix_e radix;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic               zero;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

  typedef struct packed {
    logic               start;
    logic               push;
    logic [DIGIT_W-1:0] digit;
  } emit_ctrl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pre0;
    logic [CHAR_W-1:0] pre1;
    logic [LEN_W-1:0]  b1;
    logic [LEN_W-1:0]  b2;
    logic [LEN_W-1:0]  b3;
    logic [LEN_W-1:0]  len;
    logic              sign_body;
    logic [CHAR_W-1:0] sign_ch;
    logic [CHAR_W-1:0] pad_ch;
    logic              upper;
  } layout_t;

  // first table character sits in the top byte
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[{~d, 3'b000} +: CHAR_W];
  endfunction

  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c,
                                                 input logic up);
    if (up && (c inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
      return c - CASE_DIFF;
    end
    return c;
  endfunction

endpackage

// ----- rtl/iff_radix_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iff_radix_div
// shared divide-by-radix unit: one digit per request, decimal by long
// division eight bits a cycle, power-of-two radices by a single shift
// ---------------------------------------------------------------------------
module iff_radix_div import iff_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [VALUE_BITS-1:0] load_val_i,
  output div_stat_t             stat_o
);

  localparam int DIV_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int STEPS    = DIV_BITS / 8;
  localparam int CNT_W    = $clog2(STEPS + 1);

  logic [DIV_BITS-1:0] val_q, val_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [7:0]          chunk;
  logic [7:0]          qbits;
  logic [DIGIT_W:0]    r;
  logic [CNT_W-1:0]    cnt_next;

  always_comb begin
    chunk = val_q[DIV_BITS-1 -: 8];
    r     = busy_q ? {1'b0, rem_q} : '0;
    qbits = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], chunk[i]};
      if (r >= 5'd10) begin
        r        = r - 5'd10;
        qbits[i] = 1'b1;
      end
    end
    cnt_next = busy_q ? cnt_q + 1'b1 : CNT_W'(1);
  end

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.load) begin
      val_d = DIV_BITS'(load_val_i);
    end else if (ctrl_i.start || busy_q) begin
      case (ctrl_i.radix)
        RADIX_DEC: begin
          val_d = (val_q << 8) | DIV_BITS'(qbits);
          rem_d = r[DIGIT_W-1:0];
          cnt_d = cnt_next;
          if (cnt_next == CNT_W'(STEPS)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            busy_d = 1'b1;
          end
        end
        RADIX_HEX: begin
          val_d  = val_q >> 4;
          rem_d  = val_q[3:0];
          done_d = 1'b1;
        end
        RADIX_OCT: begin
          val_d  = val_q >> 3;
          rem_d  = {1'b0, val_q[2:0]};
          done_d = 1'b1;
        end
        default: begin
          val_d  = val_q >> 1;
          rem_d  = {3'b000, val_q[0]};
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.zero  = (val_q == '0);
  assign stat_o.digit = rem_q;

endmodule

// ----- rtl/iff_char_emit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iff_char_emit
// digit stack and field sequencer, one character per cycle into the
// output register while a low m_axis_tready_i does not stall it
// ---------------------------------------------------------------------------
module iff_char_emit import iff_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  emit_ctrl_t        ctrl_i,
  input  layout_t           layout_i,
  output logic              busy_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [CHAR_W-1:0] m_axis_tdata_o,   // character
  output logic              m_axis_tlast_o
);

  localparam int STACK_W = DIGIT_W * VALUE_BITS;

  logic [STACK_W-1:0] digits_q, digits_d;
  layout_t            lay_q;
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic               active_q, active_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  logic               adv;
  logic               take_digit;
  logic               is_last;
  logic [CHAR_W-1:0]  ch;

  always_comb begin
    take_digit = 1'b0;
    if (pos_q < lay_q.b1) begin
      ch = (pos_q == '0) ? lay_q.pre0 : lay_q.pre1;
    end else if (pos_q < lay_q.b2) begin
      ch = lay_q.pad_ch;
    end else if (pos_q < lay_q.b3) begin
      if (lay_q.sign_body && (pos_q == lay_q.b2)) begin
        ch = lay_q.sign_ch;
      end else begin
        ch         = digit_char(digits_q[DIGIT_W-1:0]);
        take_digit = 1'b1;
      end
    end else begin
      ch = lay_q.pad_ch;
    end
  end

  assign adv     = active_q && (!out_valid_q || m_axis_tready_i);
  assign is_last = (pos_q == lay_q.len - 1'b1);

  always_comb begin
    digits_d    = digits_q;
    pos_d       = pos_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    // newest digit is the most significant one, kept at the bottom
    if (ctrl_i.push) begin
      digits_d = {digits_q[STACK_W-DIGIT_W-1:0], ctrl_i.digit};
    end else if (adv && take_digit) begin
      digits_d = digits_q >> DIGIT_W;
    end
    if (ctrl_i.start) begin
      pos_d    = '0;
      active_d = 1'b1;
    end
    if (adv) begin
      pos_d       = pos_q + 1'b1;
      out_valid_d = 1'b1;
      out_data_d  = to_upper(ch, lay_q.upper);
      out_last_d  = is_last;
      if (is_last) begin
        active_d = 1'b0;
      end
    end else if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q   <= digits_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    if (ctrl_i.start) begin
      lay_q <= layout_i;
    end
  end

  assign busy_o          = active_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- rtl/integer_field_formatter_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// integer_field_formatter_core
// formats one integer and its conversion spec as an ascii field, sent one
// character per item with tlast on the final character
// ---------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  s_axis   in   tvalid / tready  tdata: value, tuser: conversion spec
//  m_axis   out  tvalid / tready  tdata: character, tlast: last
//
//  per item: the sequencer passes S_START, the digit loop in S_WAIT, S_LAYOUT
//  and S_EMIT; decimal digits come from long division, binary, octal and
//  hex digits from a single shift in the shared radix divider, and the output
//  register sends one character per cycle while m_axis_tready_i allows
//  s_axis_tready_o is high only between fields; output stalls hold the field
//  reset clears the sequencer and empties the output register
// ---------------------------------------------------------------------------
module integer_field_formatter_core import iff_pkg::*; #(
  parameter int VALUE_BITS     = VALUE_BITS_DEF,
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int POINTER_DIGITS = POINTER_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [VALUE_W-1:0] s_axis_tdata_i,  // value
  // radix_sel[1:0], signed_value, upper, alt_prefix, pointer_style, plus_sign,
  // blank_sign, left_align, zero_pad, min_width[6:0], min_digits[5:0], zero fill
  input  logic [SPEC_W-1:0] s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [CHAR_W-1:0] m_axis_tdata_o,   // character
  output logic              m_axis_tlast_o
);

  localparam int PREC_W = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_LAYOUT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]        state_q, state_d;
  radix_e            radix_q;
  logic              upper_q, plus_q, left_q, zpad_q, minus_q;
  logic [LEN_W-1:0]  width_q;
  logic [PREC_W-1:0] prec_q, prec_d;
  logic [PREC_W-1:0] nd_q, nd_d;
  logic [CHAR_W-1:0] pre0_q, pre1_q;
  logic [1:0]        plen_q;

  // input decode
  logic                  accept;
  logic [VALUE_BITS-1:0] v_in, mag;
  radix_e                radix_in, radix_eff;
  logic                  f_sgn, f_up, f_alt, f_ptr, f_plus, f_blank, f_left, f_zpad;
  logic [6:0]            f_width, width_c;
  logic [5:0]            f_prec;
  logic [6:0]            prec_c;
  logic                  is_signed, negative;
  logic [CHAR_W-1:0]     pre0_c, pre1_c;
  logic [1:0]            plen_c;

  // digit loop
  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  logic [PREC_W-1:0] prec_nx, nd_nx;
  logic              more;

  // layout
  emit_ctrl_t        emit_ctrl;
  layout_t           layout;
  logic              emit_busy;
  logic              has_sign, sign_body;
  logic [CHAR_W-1:0] sign_ch, lay_pre0;
  logic [1:0]        lay_plen;
  logic [LEN_W-1:0]  blen, used, pad, lpad, total;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign v_in     = VALUE_BITS'(s_axis_tdata_i);
  assign radix_in = radix_e'(s_axis_tuser_i[1:0]);
  assign f_sgn    = s_axis_tuser_i[2];
  assign f_up     = s_axis_tuser_i[3];
  assign f_alt    = s_axis_tuser_i[4];
  assign f_ptr    = s_axis_tuser_i[5];
  assign f_plus   = s_axis_tuser_i[6];
  assign f_blank  = s_axis_tuser_i[7];
  assign f_left   = s_axis_tuser_i[8];
  assign f_zpad   = s_axis_tuser_i[9];
  assign f_width  = s_axis_tuser_i[16:10];
  assign f_prec   = s_axis_tuser_i[22:17];

  assign is_signed = !f_ptr && f_sgn && (radix_in == RADIX_DEC);
  assign negative  = is_signed && v_in[VALUE_BITS-1];
  assign mag       = negative ? (~v_in + 1'b1) : v_in;
  assign radix_eff = f_ptr ? RADIX_HEX : radix_in;

  always_comb begin
    pre0_c = CH_ZERO;
    pre1_c = CH_ZERO;
    plen_c = 2'd0;
    if (f_ptr) begin
      pre0_c = CH_MINUS;
      pre1_c = CH_GT;
      plen_c = 2'd2;
    end else if (f_alt) begin
      case (radix_in)
        RADIX_BIN: begin
          pre1_c = CH_B;
          plen_c = 2'd2;
        end
        RADIX_OCT: plen_c = 2'd1;
        RADIX_HEX: begin
          pre1_c = CH_X;
          plen_c = 2'd2;
        end
        default: plen_c = 2'd0;
      endcase
    end
    // a zero value drops any prefix under the hash flag, arrow included
    if (f_alt && (v_in == '0)) begin
      plen_c = 2'd0;
    end
    if (is_signed && !negative && f_blank) begin
      pre0_c = CH_SPACE;
      plen_c = 2'd1;
    end
  end

  always_comb begin
    prec_c = f_ptr ? 7'(POINTER_DIGITS) : {1'b0, f_prec};
    if (prec_c == '0) begin
      prec_c = 7'd1;
    end
    if (prec_c > 7'(VALUE_BITS)) begin
      prec_c = 7'(VALUE_BITS);
    end
    width_c = (f_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : f_width;
  end

  assign prec_nx = (prec_q != '0) ? prec_q - 1'b1 : '0;
  assign nd_nx   = nd_q + 1'b1;
  assign more    = ((prec_nx != '0) || !div_stat.zero) && (nd_nx < PREC_W'(VALUE_BITS));

  assign div_ctrl.load  = accept;
  assign div_ctrl.start = (state_q == S_START) ||
                          ((state_q == S_WAIT) && div_stat.done && more);
  assign div_ctrl.radix = radix_q;

  always_comb begin
    state_d = state_q;
    prec_d  = prec_q;
    nd_d    = nd_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          prec_d  = PREC_W'(prec_c);
          nd_d    = '0;
          state_d = S_START;
        end
      end
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          prec_d = prec_nx;
          nd_d   = nd_nx;
          if (!more) begin
            state_d = S_LAYOUT;
          end
        end
      end
      S_LAYOUT: state_d = S_EMIT;
      S_EMIT: begin
        if (!emit_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the sign takes the prefix place under zero padding
  always_comb begin
    has_sign = minus_q || plus_q;
    sign_ch  = minus_q ? CH_MINUS : CH_PLUS;
    if (has_sign && zpad_q) begin
      lay_pre0  = sign_ch;
      lay_plen  = 2'd1;
      sign_body = 1'b0;
    end else begin
      lay_pre0  = pre0_q;
      lay_plen  = plen_q;
      sign_body = has_sign;
    end
    blen  = LEN_W'(nd_q) + LEN_W'(sign_body);
    used  = LEN_W'(lay_plen) + blen;
    pad   = (width_q > used) ? width_q - used : '0;
    lpad  = left_q ? '0 : pad;
    total = used + pad;
  end

  assign layout.pre0      = lay_pre0;
  assign layout.pre1      = pre1_q;
  assign layout.b1        = LEN_W'(lay_plen);
  assign layout.b2        = LEN_W'(lay_plen) + lpad;
  assign layout.b3        = LEN_W'(lay_plen) + lpad + blen;
  assign layout.len       = (total > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : total;
  assign layout.sign_body = sign_body;
  assign layout.sign_ch   = sign_ch;
  assign layout.pad_ch    = zpad_q ? CH_ZERO : CH_SPACE;
  assign layout.upper     = upper_q;

  assign emit_ctrl.start = (state_q == S_LAYOUT);
  assign emit_ctrl.push  = (state_q == S_WAIT) && div_stat.done;
  assign emit_ctrl.digit = div_stat.digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prec_q  <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      prec_q  <= prec_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      radix_q <= radix_eff;
      upper_q <= f_up;
      plus_q  <= f_plus;
      left_q  <= f_left;
      zpad_q  <= f_zpad;
      minus_q <= negative;
      width_q <= LEN_W'(width_c);
      pre0_q  <= pre0_c;
      pre1_q  <= pre1_c;
      plen_q  <= plen_c;
    end
  end

  iff_radix_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .load_val_i (mag),
    .stat_o     (div_stat)
  );

  iff_char_emit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (emit_ctrl),
    .layout_i        (layout),
    .busy_o          (emit_busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `IFF_ASSERT_IMPL(a_div_done_in_loop, div_stat.done, state_q == S_WAIT, "digit outside loop")
  `IFF_ASSERT_NEXT(a_accept_starts, accept, (state_q == S_START) && !s_axis_tready_o, "bad start")
  `IFF_ASSERT_IMPL(a_emit_idle_start, emit_ctrl.start, !emit_busy, "field started while busy")

endmodule
